### src/hebfr_pkg.sv
// shared constants and types of the header/end bcc frame receiver
package hebfr_pkg;

  localparam int FRAME_DEPTH = 16;
  localparam int DEPTH_W     = $clog2(FRAME_DEPTH);
  localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);
  localparam int IDX_W       = 4;

  localparam logic [7:0] HEADER_RESET = 8'h5A;
  localparam logic [7:0] END_RESET    = 8'hFE;

  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_BCC_ERR  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic CFG_HEADER = 1'b0;
  localparam logic CFG_END    = 1'b1;

  typedef struct packed {
    logic       store_first;
    logic       store_body;
    logic       clear;
    logic       emit_start;
    logic       emit_step;
    logic       put_err;
    logic [1:0] err_status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic is_header;
    logic is_end;
    logic bcc_match;
    logic emit_last;
  } sts_t;

endpackage

### src/hebfr_ctrl.sv
// frame receiver controller state machine
module hebfr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  hebfr_pkg::sts_t   sts,
  output hebfr_pkg::cmd_t   cmd
);
  import hebfr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_BODY = 4'b0010,
    S_BCC  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   acc;

  assign busy = (state_r == S_EMIT);
  assign acc  = start && !busy;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_BODY: begin
        if (acc) begin
          if (sts.full) begin
            cmd.put_err    = 1'b1;
            cmd.err_status = ST_OVERFLOW;
            cmd.clear      = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            cmd.store_body = 1'b1;
            if (sts.is_end) begin
              state_nxt = S_BCC;
            end
          end
        end
      end
      S_BCC: begin
        if (acc) begin
          if (sts.bcc_match) begin
            cmd.emit_start = 1'b1;
            state_nxt      = S_EMIT;
          end else begin
            cmd.put_err    = 1'b1;
            cmd.err_status = ST_BCC_ERR;
            cmd.clear      = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        cmd.emit_step = 1'b1;
        if (sts.emit_last) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        if (acc && sts.is_header) begin
          cmd.store_first = 1'b1;
          state_nxt       = S_BODY;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/hebfr_datapath.sv
// frame store, count, running xor, config registers and result register
module hebfr_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_rx_byte,
  input  logic              cfg_wr_en,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_wdata,
  input  hebfr_pkg::cmd_t   cmd,
  output hebfr_pkg::sts_t   sts,
  output logic              out_strobe,
  output logic [7:0]        out_frame_byte,
  output logic [3:0]        out_byte_index,
  output logic              out_last,
  output logic [1:0]        out_status
);
  import hebfr_pkg::*;

  logic [7:0]       hdr_r;
  logic [7:0]       end_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [7:0]       xor_r;
  logic [7:0]       xor_nxt;
  logic [CNT_W-1:0] rd_idx_r;
  logic [CNT_W-1:0] rd_idx_nxt;
  logic [CNT_W-1:0] rd_idx_inc;
  logic [7:0]       mem [FRAME_DEPTH];
  logic [7:0]       rdata_r;
  logic             ov_r;
  logic [IDX_W-1:0] oi_r;
  logic             ol_r;
  logic [1:0]       os_r;

  assign rd_idx_inc    = rd_idx_r + CNT_W'(1);
  assign sts.full      = (cnt_r == CNT_W'(FRAME_DEPTH));
  assign sts.is_header = (in_rx_byte == hdr_r);
  assign sts.is_end    = (in_rx_byte == end_r);
  assign sts.bcc_match = (in_rx_byte == xor_r);
  assign sts.emit_last = (rd_idx_inc == cnt_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= HEADER_RESET;
      end_r <= END_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_HEADER: hdr_r <= cfg_wdata;
        CFG_END:    end_r <= cfg_wdata;
        default:    hdr_r <= hdr_r;
      endcase
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    xor_nxt    = xor_r;
    rd_idx_nxt = rd_idx_r;
    if (cmd.store_first) begin
      cnt_nxt = CNT_W'(1);
      xor_nxt = in_rx_byte;
    end
    if (cmd.store_body) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      xor_nxt = xor_r ^ in_rx_byte;
    end
    if (cmd.emit_start) begin
      rd_idx_nxt = '0;
    end
    if (cmd.emit_step) begin
      rd_idx_nxt = rd_idx_inc;
    end
    if (cmd.clear) begin
      cnt_nxt = '0;
      xor_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      xor_r    <= '0;
      rd_idx_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      xor_r    <= xor_nxt;
      rd_idx_r <= rd_idx_nxt;
      ov_r     <= cmd.emit_step || cmd.put_err;
    end
  end

  // frame store
  always_ff @(posedge clk) begin
    if (cmd.store_first) begin
      mem[0] <= in_rx_byte;
    end else if (cmd.store_body) begin
      mem[cnt_r[DEPTH_W-1:0]] <= in_rx_byte;
    end
    if (cmd.emit_step) begin
      rdata_r <= mem[rd_idx_r[DEPTH_W-1:0]];
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      oi_r <= IDX_W'(rd_idx_r);
      ol_r <= sts.emit_last;
      os_r <= ST_GOOD;
    end else if (cmd.put_err) begin
      oi_r <= '0;
      ol_r <= 1'b1;
      os_r <= cmd.err_status;
    end
  end

  assign out_strobe     = ov_r;
  assign out_frame_byte = (os_r == ST_GOOD) ? rdata_r : 8'd0;
  assign out_byte_index = oi_r;
  assign out_last       = ol_r;
  assign out_status     = os_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FRAME_DEPTH))
    else $error("byte count beyond store depth");

  a_read_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_step |-> (rd_idx_r < cnt_r))
    else $error("read beyond stored frame");

  a_emit_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_start |=> (rd_idx_r == '0))
    else $error("emit does not begin at header");

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != ST_GOOD)) |-> out_last)
    else $error("error item not marked last");

endmodule

### src/header_end_bcc_frame_receiver_core.sv
// top level of the header/end bcc frame receiver
//
// usage
//   input: one received byte on in_rx_byte, taken at a clock edge with start
//   high and busy low. a byte is taken in a single cycle while busy is low.
//   results: out_strobe marks one item for exactly one cycle with
//   out_frame_byte, out_byte_index, out_last and out_status; the receiver
//   cannot stall and must take every item as it is shown.
//   config: cfg_wr_en with cfg_index 0 (header value) or 1 (end value) and
//   cfg_wdata writes a register at the clock edge; write only while idle.
// timing
//   a checksum or overflow error item appears the cycle after its byte.
//   after a matching bcc byte busy stays high while the n frame bytes are
//   read, n the frame length (up to 16), and the bytes come out one per cycle
//   through the registered store read and strobe; each step reads one byte
//   from the frame store, which sets this pace.
// reset
//   rst_n low at a clock edge returns to waiting for a header, clears the
//   count and xor and restores header 0x5a and end 0xfe.
module header_end_bcc_frame_receiver_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_rx_byte,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  output logic       out_strobe,
  output logic [7:0] out_frame_byte,
  output logic [3:0] out_byte_index,
  output logic       out_last,
  output logic [1:0] out_status
);
  import hebfr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hebfr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  hebfr_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_rx_byte     (in_rx_byte),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .sts            (sts),
    .out_strobe     (out_strobe),
    .out_frame_byte (out_frame_byte),
    .out_byte_index (out_byte_index),
    .out_last       (out_last),
    .out_status     (out_status)
  );

endmodule
